// File: hdl/bmac_pkg.sv
// ----------------------------------------------------------------------------
// bmac_pkg
// Shared types, codes and field widths of the bit-map allocator.
// ----------------------------------------------------------------------------
package bmac_pkg;

   localparam int FUNC_W     = 4;
   localparam int IDX_W      = 10;
   localparam int SIZE_W     = 11;
   localparam int CNT_W      = 11;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [FUNC_W-1:0] {
      FN_READ      = 4'd0,
      FN_WRITE     = 4'd1,
      FN_TSET      = 4'd2,
      FN_TCLR      = 4'd3,
      FN_FIND_ONE  = 4'd4,
      FN_FIND_CLR  = 4'd5,
      FN_FIND_ZERO = 4'd6,
      FN_FIND_SET  = 4'd7,
      FN_REFILL    = 4'd8
   } func_type;

   typedef enum logic [1:0] {
      CL_NONE,
      CL_INDEXED,
      CL_SEARCH,
      CL_REFILL
   } class_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_LOCATE,
      ST_UPDATE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic accept;
      logic decode;
      logic read;
      logic locate;
      logic update;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      class_type cls;
      logic      idx_err;
      logic      any_cand;
      logic      rsp_free;
   } sts_type;

   function automatic class_type func_class(input logic [FUNC_W-1:0] f);
      class_type r;
      r = CL_NONE;
      case (f) inside
         FN_READ, FN_WRITE, FN_TSET, FN_TCLR:               r = CL_INDEXED;
         FN_FIND_ONE, FN_FIND_CLR, FN_FIND_ZERO, FN_FIND_SET: r = CL_SEARCH;
         FN_REFILL:                                         r = CL_REFILL;
         default:                                           r = CL_NONE;
      endcase
      return r;
   endfunction

endpackage

// File: hdl/bitmap_allocator_with_count.sv
// ----------------------------------------------------------------------------
// bitmap_allocator_with_count
// Bit-map allocator with running ones count: indexed read/write/test,
// lowest set or clear bit search with optional flip, and whole-map refill.
//
//   channel   dir   beat content
//   req_      in    func, bit_index, set_value
//   rsp_      out   old_value, found, found_index, index_error, ones, zeros
//   csr_      in    size_in_use (clamped, clears the map)
//
// Indexed and found searches pass the accept, decode, word read, locate,
// update and result load steps around the single-port word memory; misses,
// errors and unused codes go from decode to result load, refill to update.
// Per-word summary flags make a search one priority encode and one word read.
// A size write clears the map in the same cycle; no clearing pass is needed.
// The result register holds while rsp_tready is low; the next beat waits only
// at result load.
// ----------------------------------------------------------------------------
module bitmap_allocator_with_count #(
   parameter int MAX_MAP_BITS = 1024,
   parameter int WORD_BITS    = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // func[3:0], bit_index[13:4], set_value[14], zero pad
   input  logic [bmac_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // old_value[0], found[1], found_index[11:2], index_error[12],
   // ones_total[23:13], zeros_total[34:24], zero pad
   output logic [bmac_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_we,
   input  logic [bmac_pkg::SIZE_W-1:0]      csr_wdata
);

   bmac_pkg::cmd_type cmd;
   bmac_pkg::sts_type sts;

   bmac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bmac_dp #(
      .MAX_MAP_BITS (MAX_MAP_BITS),
      .WORD_BITS    (WORD_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while a previous one is in flight");

   a_found_err_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[1] && rsp_tdata[12]))
      else $error("found and index_error both set");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.load_rsp))
      else $error("result appeared without a load");

endmodule

// File: hdl/bmac_ctrl.sv
// ----------------------------------------------------------------------------
// bmac_ctrl
// Sequencer of the allocator: steps one request through decode, then as its
// class needs word read, bit location and update, then result load.
// ----------------------------------------------------------------------------
module bmac_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  bmac_pkg::sts_type  sts,
   output bmac_pkg::cmd_type  cmd
);

   bmac_pkg::state_type state_ff;
   bmac_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmac_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bmac_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = bmac_pkg::ST_DECODE;
            end
         end
         bmac_pkg::ST_DECODE: begin
            if (sts.cls == bmac_pkg::CL_REFILL) begin
               state_in = bmac_pkg::ST_UPDATE;
            end else if (sts.cls == bmac_pkg::CL_INDEXED && !sts.idx_err) begin
               state_in = bmac_pkg::ST_READ;
            end else if (sts.cls == bmac_pkg::CL_SEARCH && sts.any_cand) begin
               state_in = bmac_pkg::ST_READ;
            end else begin
               state_in = bmac_pkg::ST_RESULT;
            end
         end
         bmac_pkg::ST_READ:   state_in = bmac_pkg::ST_LOCATE;
         bmac_pkg::ST_LOCATE: state_in = bmac_pkg::ST_UPDATE;
         bmac_pkg::ST_UPDATE: state_in = bmac_pkg::ST_RESULT;
         bmac_pkg::ST_RESULT: begin
            if (sts.rsp_free) begin
               state_in = bmac_pkg::ST_IDLE;
            end
         end
         default: state_in = bmac_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         bmac_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         bmac_pkg::ST_DECODE: cmd.decode = 1'b1;
         bmac_pkg::ST_READ:   cmd.read   = 1'b1;
         bmac_pkg::ST_LOCATE: cmd.locate = 1'b1;
         bmac_pkg::ST_UPDATE: cmd.update = 1'b1;
         bmac_pkg::ST_RESULT: cmd.load_rsp = sts.rsp_free;
         default: cmd = '0;
      endcase
   end

endmodule

// File: hdl/bmac_dp.sv
// ----------------------------------------------------------------------------
// bmac_dp
// Datapath of the allocator: word memory, per-word summary flags, size and
// ones count, word/bit locate logic and the result register.
// ----------------------------------------------------------------------------
module bmac_dp #(
   parameter int MAX_MAP_BITS = 1024,
   parameter int WORD_BITS    = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bmac_pkg::cmd_type                   cmd,
   output bmac_pkg::sts_type                   sts,
   input  logic [bmac_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                csr_we,
   input  logic [bmac_pkg::SIZE_W-1:0]         csr_wdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bmac_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int WC     = (MAX_MAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int W_AW   = (WC > 1) ? $clog2(WC) : 1;
   localparam int B_W    = $clog2(WORD_BITS);
   localparam int BI_W   = $clog2(WC * WORD_BITS);
   localparam int SZ_B   = $clog2(MAX_MAP_BITS + 1);
   localparam int SZ_W   = (SZ_B > bmac_pkg::SIZE_W) ? SZ_B : bmac_pkg::SIZE_W;
   localparam int RW     = ((SZ_W > BI_W) ? SZ_W : BI_W) + 1;
   localparam int NW     = SZ_W + 1;
   localparam int K      = NW + 7;
   localparam int PW     = NW + K;
   localparam logic [K-1:0] RECIP = K'(((64'd1 << K) + WORD_BITS - 1) / WORD_BITS);
   localparam logic [SZ_W-1:0] SIZE_MAX = SZ_W'(MAX_MAP_BITS);
   localparam logic [W_AW:0]   WC_RST   = (W_AW + 1)'(WC);

   logic [WORD_BITS-1:0] mem_ff [WC];
   logic [WORD_BITS-1:0] rdata_ff;

   logic [SZ_W-1:0]   size_ff;
   logic [SZ_W-1:0]   ones_ff;
   logic [W_AW:0]     wiu_ff;
   logic [WC-1:0]     has_one_ff;
   logic [WC-1:0]     full_ff;

   logic [bmac_pkg::FUNC_W-1:0] func_ff;
   logic [bmac_pkg::IDX_W-1:0]  idx_ff;
   logic                        nv_ff;

   logic [W_AW-1:0]      word_ff;
   logic                 found_ff;
   logic [BI_W-1:0]      base_ff;
   logic                 hone_ff;
   logic                 hfull_ff;
   logic [WORD_BITS-1:0] eff_ff;
   logic [WORD_BITS-1:0] mask_ff;
   logic [B_W-1:0]       bit_ff;
   logic                 old_ff;
   logic [BI_W-1:0]      findex_ff;

   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic [bmac_pkg::RSP_DATA_W-1:0]     rsp_data_ff;

   bmac_pkg::class_type   cls;
   logic                  want_one;
   logic [WC-1:0]         in_use;
   logic [WC-1:0]         cand;
   logic [SZ_W-1:0]       cfg_size;
   logic [PW-1:0]         wiu_prod;
   logic [PW-1:0]         idx_prod;
   logic [RW-1:0]         rem;
   logic [RW-1:0]         bit_off;
   logic [WORD_BITS-1:0]  mask;
   logic [WORD_BITS-1:0]  eff;
   logic [WORD_BITS-1:0]  seek;
   logic                  new_bit;
   logic                  cur_bit;
   logic [WORD_BITS-1:0]  new_word;
   logic                  idx_err;

   function automatic logic [W_AW-1:0] first_word(input logic [WC-1:0] v);
      logic [W_AW-1:0] r;
      r = '0;
      for (int i = WC - 1; i >= 0; i--) begin
         if (v[i]) r = W_AW'(i);
      end
      return r;
   endfunction

   function automatic logic [B_W-1:0] first_bit(input logic [WORD_BITS-1:0] v);
      logic [B_W-1:0] r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) r = B_W'(i);
      end
      return r;
   endfunction

   assign cls      = bmac_pkg::func_class(func_ff);
   assign want_one = (func_ff == bmac_pkg::FN_FIND_ONE) || (func_ff == bmac_pkg::FN_FIND_CLR);
   assign idx_err  = SZ_W'(idx_ff) >= size_ff;

   always_comb begin
      for (int i = 0; i < WC; i++) begin
         in_use[i] = (W_AW + 1)'(i) < wiu_ff;
      end
      cand = want_one ? has_one_ff : (in_use & ~(has_one_ff & full_ff));
   end

   assign sts.cls      = cls;
   assign sts.idx_err  = idx_err;
   assign sts.any_cand = |cand;
   assign sts.rsp_free = !rsp_valid_ff || rsp_tready;

   // clamp the written size to 1..MAX_MAP_BITS
   always_comb begin
      cfg_size = SZ_W'(csr_wdata);
      if (cfg_size == '0) begin
         cfg_size = SZ_W'(1);
      end else if (cfg_size > SIZE_MAX) begin
         cfg_size = SIZE_MAX;
      end
   end

   // divide by the word width through a scaled reciprocal
   assign wiu_prod = PW'(NW'(size_ff) + NW'(WORD_BITS - 1)) * PW'(RECIP);
   assign idx_prod = PW'(idx_ff) * PW'(RECIP);

   always_comb begin
      rem     = RW'(size_ff) - RW'(base_ff);
      bit_off = RW'(idx_ff) - RW'(base_ff);
      for (int j = 0; j < WORD_BITS; j++) begin
         mask[j] = rem > RW'(j);
      end
      eff  = hone_ff ? (hfull_ff ? mask : rdata_ff) : '0;
      seek = want_one ? eff : (~eff & mask);
   end

   always_comb begin
      cur_bit = eff_ff[bit_ff];
      case (func_ff)
         bmac_pkg::FN_WRITE:    new_bit = nv_ff;
         bmac_pkg::FN_TSET:     new_bit = 1'b1;
         bmac_pkg::FN_TCLR:     new_bit = 1'b0;
         bmac_pkg::FN_FIND_CLR: new_bit = 1'b0;
         bmac_pkg::FN_FIND_SET: new_bit = 1'b1;
         default:               new_bit = cur_bit;
      endcase
      new_word         = eff_ff;
      new_word[bit_ff] = new_bit;
   end

   always_ff @(posedge clock) begin
      if (cmd.update && cls != bmac_pkg::CL_REFILL) begin
         mem_ff[word_ff] <= new_word;
      end
      if (cmd.read) begin
         rdata_ff <= mem_ff[word_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff    <= SIZE_MAX;
         wiu_ff     <= WC_RST;
         ones_ff    <= '0;
         has_one_ff <= '0;
      end else begin
         wiu_ff <= (W_AW + 1)'(wiu_prod[PW-1:K]);
         if (csr_we) begin
            size_ff    <= cfg_size;
            ones_ff    <= '0;
            has_one_ff <= '0;
         end else if (cmd.update) begin
            if (cls == bmac_pkg::CL_REFILL) begin
               has_one_ff <= nv_ff ? in_use : '0;
               ones_ff    <= nv_ff ? size_ff : '0;
            end else begin
               has_one_ff[word_ff] <= |new_word;
               if (new_bit && !cur_bit) begin
                  ones_ff <= ones_ff + SZ_W'(1);
               end else if (!new_bit && cur_bit) begin
                  ones_ff <= ones_ff - SZ_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         if (cls == bmac_pkg::CL_REFILL) begin
            full_ff <= '1;
         end else begin
            full_ff[word_ff] <= (new_word == mask_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff <= req_tdata[3:0];
         idx_ff  <= req_tdata[13:4];
         nv_ff   <= req_tdata[14];
      end
      if (cmd.decode) begin
         found_ff <= (cls == bmac_pkg::CL_SEARCH) && (|cand);
         if (cls == bmac_pkg::CL_SEARCH) begin
            word_ff <= first_word(cand);
         end else begin
            word_ff <= W_AW'(idx_prod[PW-1:K]);
         end
      end
      if (cmd.read) begin
         base_ff  <= BI_W'(word_ff) * BI_W'(WORD_BITS);
         hone_ff  <= has_one_ff[word_ff];
         hfull_ff <= full_ff[word_ff];
      end
      if (cmd.locate) begin
         eff_ff  <= eff;
         mask_ff <= mask;
         bit_ff  <= (cls == bmac_pkg::CL_SEARCH) ? first_bit(seek) : B_W'(bit_off);
      end
      if (cmd.update) begin
         old_ff    <= cur_bit;
         findex_ff <= base_ff + BI_W'(bit_ff);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff <= {
            5'd0,
            bmac_pkg::CNT_W'(size_ff - ones_ff),
            bmac_pkg::CNT_W'(ones_ff),
            (cls == bmac_pkg::CL_INDEXED) && idx_err,
            found_ff ? bmac_pkg::IDX_W'(findex_ff) : bmac_pkg::IDX_W'(0),
            found_ff,
            (cls == bmac_pkg::CL_INDEXED) && !idx_err && old_ff
         };
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: dv/alloc_tb_pkg.sv
// ----------------------------------------------------------------------------
// alloc_tb_pkg
// Shadow bit map of the allocator. Every accepted request updates the shadow
// and queues the result it should produce. Every result taken from the block
// is checked field by field against the oldest queued one.
// ----------------------------------------------------------------------------
package alloc_tb_pkg;

   localparam int MAP_BITS  = 1024;
   localparam int WORD_SIZE = 64;

   // low bit first: old_value, found, found_index, index_error, ones, zeros
   typedef struct packed {
      logic [bmac_pkg::CNT_W-1:0] zeros_total;
      logic [bmac_pkg::CNT_W-1:0] ones_total;
      logic                       index_error;
      logic [bmac_pkg::IDX_W-1:0] found_index;
      logic                       found;
      logic                       old_value;
   } alloc_result_type;

   localparam int RESULT_W = $bits(alloc_result_type);

   class bitmap_scoreboard_type;

      bit [MAP_BITS-1:0] map_bits;
      int unsigned       ones_count;
      int unsigned       size;
      int unsigned       errors;
      alloc_result_type  pending_results[$];

      function new();
         map_bits   = '0;
         ones_count = 0;
         size       = MAP_BITS;
         errors     = 0;
      endfunction

      function void set_size(input logic [bmac_pkg::SIZE_W-1:0] value);
         if (value == 0) begin
            size = 1;
         end else if (value > MAP_BITS) begin
            size = MAP_BITS;
         end else begin
            size = 32'(value);
         end
         map_bits   = '0;
         ones_count = 0;
      endfunction

      function void put_bit(input logic [bmac_pkg::IDX_W-1:0] i, input logic v);
         if (map_bits[i] != v) begin
            map_bits[i] = v;
            if (v) ones_count++;
            else ones_count--;
         end
      endfunction

      function void note_request(input logic [bmac_pkg::FUNC_W-1:0] f,
                                 input logic [bmac_pkg::IDX_W-1:0] idx,
                                 input logic nv);
         alloc_result_type r;
         logic             cur;
         logic             nxt;
         logic             want;
         int unsigned      i;
         r = '0;
         case (f) inside
            bmac_pkg::FN_READ, bmac_pkg::FN_WRITE, bmac_pkg::FN_TSET,
            bmac_pkg::FN_TCLR: begin
               if (idx >= size) begin
                  r.index_error = 1'b1;
               end else begin
                  cur         = map_bits[idx];
                  r.old_value = cur;
                  case (f)
                     bmac_pkg::FN_WRITE: nxt = nv;
                     bmac_pkg::FN_TSET:  nxt = 1'b1;
                     bmac_pkg::FN_TCLR:  nxt = 1'b0;
                     default:            nxt = cur;
                  endcase
                  put_bit(idx, nxt);
               end
            end
            bmac_pkg::FN_FIND_ONE, bmac_pkg::FN_FIND_CLR, bmac_pkg::FN_FIND_ZERO,
            bmac_pkg::FN_FIND_SET: begin
               want = (f == bmac_pkg::FN_FIND_ONE || f == bmac_pkg::FN_FIND_CLR);
               for (i = 0; i < size; i++) begin
                  if (map_bits[bmac_pkg::IDX_W'(i)] == want) begin
                     r.found       = 1'b1;
                     r.found_index = bmac_pkg::IDX_W'(i);
                     if (f == bmac_pkg::FN_FIND_CLR || f == bmac_pkg::FN_FIND_SET) begin
                        put_bit(bmac_pkg::IDX_W'(i), !want);
                     end
                     break;
                  end
               end
            end
            bmac_pkg::FN_REFILL: begin
               map_bits   = '0;
               ones_count = 0;
               if (nv) begin
                  for (i = 0; i < size; i++) map_bits[bmac_pkg::IDX_W'(i)] = 1'b1;
                  ones_count = size;
               end
            end
            default: ;
         endcase
         r.ones_total    = bmac_pkg::CNT_W'(ones_count);
         r.zeros_total   = bmac_pkg::CNT_W'(size - ones_count);
         pending_results = {pending_results, r};
      endfunction

      task report(input string msg);
         $display("bitmap mismatch: %s", msg);
         errors++;
      endtask

      task check_field(input string name, input int unsigned got, input int unsigned want);
         if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
      endtask

      task check_result(input logic [bmac_pkg::RSP_DATA_W-1:0] data);
         alloc_result_type got;
         alloc_result_type want;
         got = data[RESULT_W-1:0];
         if (pending_results.size() == 0) begin
            report($sformatf("result with nothing pending, beat %h", data));
            return;
         end
         want = pending_results.pop_front();
         check_field("old_value", 32'(got.old_value), 32'(want.old_value));
         check_field("found", 32'(got.found), 32'(want.found));
         check_field("found_index", 32'(got.found_index), 32'(want.found_index));
         check_field("index_error", 32'(got.index_error), 32'(want.index_error));
         check_field("ones_total", 32'(got.ones_total), 32'(want.ones_total));
         check_field("zeros_total", 32'(got.zeros_total), 32'(want.zeros_total));
      endtask

   endclass

endpackage

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Bench for bitmap_allocator_with_count. A short directed run covers the
// field extremes, every operation, out-of-range indices, search misses,
// refills and unused codes; then random allocator traffic over a series of
// map sizes, written between phases while the block is idle. Both stream
// sides idle at random, and the result side holds off once for long enough
// to back the block up into its request side.
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int HOLD_AT_BEAT    = 340;
   localparam int HOLD_CYCLES     = 200;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [bmac_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [bmac_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            csr_we;
   logic [bmac_pkg::SIZE_W-1:0]     csr_wdata;

   alloc_tb_pkg::bitmap_scoreboard_type sb;
   bit                                  steady;
   int unsigned                         results_seen;
   int unsigned                         hold_left;
   bit                                  held;

   bitmap_allocator_with_count #(
      .MAX_MAP_BITS(alloc_tb_pkg::MAP_BITS),
      .WORD_BITS   (alloc_tb_pkg::WORD_SIZE)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("tb_top: errors");
      $finish;
   end

   initial begin
      rsp_tready   <= 1'b0;
      results_seen = 0;
      hold_left    = 0;
      held         = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata);
            results_seen++;
         end
         if (!held && results_seen == HOLD_AT_BEAT) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= 24);
         end
      end
   end

   task automatic send_req(input logic [bmac_pkg::FUNC_W-1:0] f,
                           input logic [bmac_pkg::IDX_W-1:0] idx,
                           input logic nv);
      req_tvalid <= 1'b1;
      req_tdata  <= bmac_pkg::REQ_DATA_W'({nv, idx, f});
      do @(posedge clock); while (!req_tready);
      sb.note_request(f, idx, nv);
      if (!steady && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 50);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_size(input logic [bmac_pkg::SIZE_W-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_size(value);
      csr_we <= 1'b0;
   endtask

   function automatic logic [bmac_pkg::IDX_W-1:0] pick_index(input int unsigned sz);
      int unsigned r;
      int unsigned lo;
      int unsigned near;
      r    = $urandom_range(99);
      lo   = (sz < 32) ? sz : 32;
      near = sz - 1 + $urandom_range(2);
      if (r < 45) return bmac_pkg::IDX_W'($urandom_range(lo - 1));
      if (r < 80) return bmac_pkg::IDX_W'($urandom_range(sz - 1));
      if (r < 92) begin
         return bmac_pkg::IDX_W'((near > alloc_tb_pkg::MAP_BITS - 1) ?
                                 alloc_tb_pkg::MAP_BITS - 1 : near);
      end
      return bmac_pkg::IDX_W'($urandom());
   endfunction

   task automatic random_request(input int unsigned sz);
      int unsigned                 r;
      logic [bmac_pkg::FUNC_W-1:0] f;
      r = $urandom_range(99);
      if (r < 12) f = bmac_pkg::FN_READ;
      else if (r < 24) f = bmac_pkg::FN_WRITE;
      else if (r < 38) f = bmac_pkg::FN_TSET;
      else if (r < 52) f = bmac_pkg::FN_TCLR;
      else if (r < 58) f = bmac_pkg::FN_FIND_ONE;
      else if (r < 68) f = bmac_pkg::FN_FIND_CLR;
      else if (r < 74) f = bmac_pkg::FN_FIND_ZERO;
      else if (r < 86) f = bmac_pkg::FN_FIND_SET;
      else if (r < 90) f = bmac_pkg::FN_REFILL;
      else if (r < 94) begin
         do f = bmac_pkg::FUNC_W'($urandom()); while (f <= bmac_pkg::FN_REFILL);
      end else begin
         f = bmac_pkg::FUNC_W'($urandom());
      end
      if (r >= 94) send_req(f, bmac_pkg::IDX_W'($urandom()), 1'($urandom()));
      else send_req(f, pick_index(sz), 1'($urandom()));
   endtask

   initial begin
      int unsigned                 phase_size[7];
      logic [bmac_pkg::SIZE_W-1:0] value;
      int                          p;
      phase_size = '{2047, 1, 64, 65, 3, 1000, 1024};
      sb         = new();
      steady     = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_wdata  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_req(bmac_pkg::FN_READ, '0, 1'b0);
      send_req(bmac_pkg::FN_WRITE, '1, 1'b1);
      send_req(bmac_pkg::FN_READ, '1, 1'b0);
      send_req(bmac_pkg::FN_TSET, '0, 1'b1);
      send_req(bmac_pkg::FN_TSET, '0, 1'b0);
      send_req(bmac_pkg::FN_TCLR, '0, 1'b1);
      send_req(bmac_pkg::FN_TCLR, '0, 1'b0);
      send_req(bmac_pkg::FN_FIND_ONE, '0, 1'b0);
      send_req(bmac_pkg::FN_FIND_ZERO, '1, 1'b1);
      send_req(bmac_pkg::FN_FIND_SET, '0, 1'b0);
      send_req(bmac_pkg::FN_FIND_CLR, '0, 1'b0);
      send_req(bmac_pkg::FN_FIND_CLR, '0, 1'b0);
      send_req(bmac_pkg::FN_FIND_CLR, '0, 1'b0);
      send_req(bmac_pkg::FN_REFILL, '0, 1'b1);
      send_req(bmac_pkg::FN_FIND_ZERO, '0, 1'b0);
      send_req(bmac_pkg::FN_FIND_SET, '0, 1'b0);
      send_req(bmac_pkg::FN_WRITE, 10'h2AA, 1'b0);
      send_req(bmac_pkg::FN_FIND_ZERO, '0, 1'b0);
      send_req(bmac_pkg::FN_READ, 10'h155, 1'b0);
      send_req(bmac_pkg::FN_REFILL, '1, 1'b0);
      send_req(bmac_pkg::FN_FIND_ONE, '0, 1'b0);
      send_req(bmac_pkg::FUNC_W'(bmac_pkg::FN_REFILL + 1), '0, 1'b0);
      send_req('1, '1, 1'b1);
      write_size('0);
      send_req(bmac_pkg::FN_WRITE, 10'd1, 1'b1);
      send_req(bmac_pkg::FN_READ, '1, 1'b0);
      send_req(bmac_pkg::FN_REFILL, '0, 1'b1);

      for (p = 0; p < PHASES; p++) begin
         value = (p < 7) ? bmac_pkg::SIZE_W'(phase_size[p]) :
                           bmac_pkg::SIZE_W'($urandom_range(2047));
         write_size(value);
         steady = (p == 3);
         repeat (ITEMS_PER_PHASE) random_request(sb.size);
      end

      steady = 1'b0;
      drain();
      if (sb.errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
